/* rtl/core/rgbe_pkg.sv */
// ----------------------------------------------------------------------------
// rgbe_pkg
// Shared types and constants for the RGBE scanline run-length decoder.
// ----------------------------------------------------------------------------
package rgbe_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CH_W      = 2;
    localparam int unsigned POS_W     = 16;
    localparam int unsigned STATUS_W  = 2;

    localparam logic [POS_W-1:0] LINE_WIDTH_RESET = 16'd1024;
    localparam logic [POS_W-1:0] MIN_RLE_WIDTH    = 16'd8;
    localparam logic [POS_W-1:0] MAX_RLE_WIDTH    = 16'h7fff;

    localparam logic [BYTE_W-1:0] HDR_MARK   = 8'h02;
    localparam logic [BYTE_W-1:0] RUN_FLAG   = 8'h80;
    localparam logic [BYTE_W-1:0] COUNT_MASK = 8'h7f;

    // Most beats one input byte can produce (header replay).
    localparam int unsigned MAX_RES      = 4;
    localparam int unsigned QUEUE_DEPTH  = 8;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CLIP     = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0]     channel;
        logic [POS_W-1:0]    start_x;
        logic [BYTE_W-1:0]   span_length;
        logic [BYTE_W-1:0]   value;
        logic                line_done;
        logic [STATUS_W-1:0] status;
        logic                last;
    } span_t;

    function automatic span_t make_span(
        input logic [CH_W-1:0]     ch,
        input logic [POS_W-1:0]    x,
        input logic [BYTE_W-1:0]   len,
        input logic [BYTE_W-1:0]   val,
        input logic                done,
        input logic [STATUS_W-1:0] st
    );
        span_t s;
        s.channel     = ch;
        s.start_x     = x;
        s.span_length = len;
        s.value       = val;
        s.line_done   = done;
        s.status      = st;
        s.last        = 1'b0;
        return s;
    endfunction

endpackage

/* rtl/core/rgbe_byte_if.sv */
// ----------------------------------------------------------------------------
// rgbe_byte_if
// Valid/ready channel carrying one byte of the encoded stream per beat.
// ----------------------------------------------------------------------------
interface rgbe_byte_if
    import rgbe_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

/* rtl/core/rgbe_span_if.sv */
// ----------------------------------------------------------------------------
// rgbe_span_if
// Valid/ready channel carrying one decoded span write per beat.
// ----------------------------------------------------------------------------
interface rgbe_span_if
    import rgbe_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     channel;
    logic [POS_W-1:0]    start_x;
    logic [BYTE_W-1:0]   span_length;
    logic [BYTE_W-1:0]   value;
    logic                line_done;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, output channel, output start_x, output span_length,
                    output value, output line_done, output status, output last,
                    input ready);
    modport sink   (input valid, input channel, input start_x, input span_length,
                    input value, input line_done, input status, input last,
                    output ready);
endinterface

/* rtl/core/rgbe_scanline_rle_decoder.sv */
// ----------------------------------------------------------------------------
// rgbe_scanline_rle_decoder
// Decodes Radiance RGBE scanlines (run-length or raw) into span write beats.
// ----------------------------------------------------------------------------
// A taken byte's span beats are written into the registered result queue.
// Throughput: 1 byte per cycle while ready; each byte pushes 0..4 beats into
//   a result queue that drains 1 beat per cycle while the sink is ready, so
//   only the header replay (old-format line) pushes 4 beats for one byte.
// The byte channel is ready while the queue has room for 4 beats.
// Reset (async, rst_n low): line_width = 1024, awaiting line header, queue empty.
// ----------------------------------------------------------------------------
module rgbe_scanline_rle_decoder
    import rgbe_pkg::*;
#(
    // Result queue entries; power of two, at least MAX_RES.
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [POS_W-1:0]   cfg_data,
    rgbe_byte_if.sink          byte_in,
    rgbe_span_if.source        span_out
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned RN_W  = $clog2(MAX_RES + 1);

    // Decode phase codes
    localparam logic [2:0] PH_HEADER = 3'd0;  // collecting 4-byte line header
    localparam logic [2:0] PH_RAW    = 3'd1;  // raw r,g,b,e pixels
    localparam logic [2:0] PH_CODE   = 3'd2;  // expecting run/literal code byte
    localparam logic [2:0] PH_RUNVAL = 3'd3;  // expecting the run value
    localparam logic [2:0] PH_LIT    = 3'd4;  // inside literal bytes

    // ------------------------------------------------------------------
    // Decode state
    // ------------------------------------------------------------------
    logic [POS_W-1:0]  line_width_reg;
    logic [2:0]        phase_reg, phase_next;
    logic [1:0]        hcnt_reg, hcnt_next;
    logic [BYTE_W-1:0] hb_reg [3];
    logic [BYTE_W-1:0] hb_next [3];
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] pend_reg, pend_next;

    // Result queue
    span_t             queue_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              take, pop;
    logic [BYTE_W-1:0] b;
    span_t             res [MAX_RES];
    logic [RN_W-1:0]   res_n;
    logic              restart;

    // Helpers used by the decode phases
    logic              lw_zero, lw_one, out_of_range, rle_hdr;
    logic [POS_W-1:0]  avail, run_end, lit_end, pos_inc;
    logic [BYTE_W-1:0] run_len, pend_dec;
    logic              run_clip;

    assign take = byte_in.valid && byte_in.ready;
    assign pop  = span_out.valid && span_out.ready;
    assign b    = byte_in.data_byte;

    assign byte_in.ready = (cnt_reg <= CNT_W'(DEPTH - MAX_RES));

    assign lw_zero      = (line_width_reg == '0);
    assign lw_one       = (line_width_reg == POS_W'(1));
    assign out_of_range = (line_width_reg < MIN_RLE_WIDTH) ||
                          (line_width_reg > MAX_RLE_WIDTH);
    assign rle_hdr      = (hb_reg[0] == HDR_MARK) && (hb_reg[1] == HDR_MARK) &&
                          !hb_reg[2][BYTE_W-1];

    // Run clipping against the line end
    assign avail    = (line_width_reg > pos_reg) ? (line_width_reg - pos_reg) : '0;
    assign run_clip = (avail < {{(POS_W-BYTE_W){1'b0}}, pend_reg});
    assign run_len  = run_clip ? avail[BYTE_W-1:0] : pend_reg;
    assign run_end  = pos_reg + {{(POS_W-BYTE_W){1'b0}}, run_len};
    assign pos_inc  = pos_reg + POS_W'(1);
    assign lit_end  = (pos_reg < line_width_reg) ? pos_inc : pos_reg;
    assign pend_dec = (pend_reg == '0) ? '0 : pend_reg - BYTE_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        hcnt_next  = hcnt_reg;
        hb_next    = hb_reg;
        ch_next    = ch_reg;
        pos_next   = pos_reg;
        pend_next  = pend_reg;
        res_n      = '0;
        restart    = 1'b0;
        for (int i = 0; i < MAX_RES; i++)
        begin
            res[i] = '0;
        end

        if (take)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hcnt_reg == 2'd0 && out_of_range)
                    begin
                        // Width outside RLE range: raw pixels from the first byte
                        res_n = RN_W'(1);
                        if (lw_zero)
                        begin
                            res[0]  = make_span('0, '0, '0, b, 1'b1, ST_CLIP);
                            restart = 1'b1;
                        end
                        else
                        begin
                            res[0]     = make_span('0, '0, BYTE_W'(1), b, 1'b0, ST_OK);
                            ch_next    = CH_W'(1);
                            phase_next = PH_RAW;
                        end
                    end
                    else if (hcnt_reg != 2'd3)
                    begin
                        hb_next[hcnt_reg] = b;
                        hcnt_next         = hcnt_reg + 2'd1;
                    end
                    else
                    begin
                        hcnt_next = '0;
                        if (!rle_hdr)
                        begin
                            // Old-format line: header bytes are pixel 0
                            if (lw_zero)
                            begin
                                res_n   = RN_W'(1);
                                res[0]  = make_span('0, '0, '0, hb_reg[0], 1'b1, ST_CLIP);
                                restart = 1'b1;
                            end
                            else
                            begin
                                res_n  = RN_W'(MAX_RES);
                                res[0] = make_span(CH_W'(0), '0, BYTE_W'(1), hb_reg[0],
                                                   1'b0, ST_OK);
                                res[1] = make_span(CH_W'(1), '0, BYTE_W'(1), hb_reg[1],
                                                   1'b0, ST_OK);
                                res[2] = make_span(CH_W'(2), '0, BYTE_W'(1), hb_reg[2],
                                                   1'b0, ST_OK);
                                res[3] = make_span(CH_W'(3), '0, BYTE_W'(1), b,
                                                   lw_one, ST_OK);
                                if (lw_one)
                                begin
                                    restart = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_RAW;
                                    pos_next   = POS_W'(1);
                                end
                            end
                        end
                        else if ({hb_reg[2], b} != line_width_reg)
                        begin
                            res_n   = RN_W'(1);
                            res[0]  = make_span('0, '0, '0, '0, 1'b1, ST_MISMATCH);
                            restart = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_CODE;
                        end
                    end
                end

                PH_RAW:
                begin
                    res_n = RN_W'(1);
                    if (pos_reg >= line_width_reg)
                    begin
                        res[0]  = make_span(ch_reg, pos_reg, '0, b, 1'b1, ST_CLIP);
                        restart = 1'b1;
                    end
                    else
                    begin
                        res[0]  = make_span(ch_reg, pos_reg, BYTE_W'(1), b, 1'b0, ST_OK);
                        ch_next = ch_reg + CH_W'(1);
                        if (ch_reg == CH_W'(3))
                        begin
                            pos_next = pos_inc;
                            if (pos_inc >= line_width_reg)
                            begin
                                res[0].line_done = 1'b1;
                                restart          = 1'b1;
                            end
                        end
                    end
                end

                PH_CODE:
                begin
                    if (b > RUN_FLAG)
                    begin
                        pend_next  = b & COUNT_MASK;
                        phase_next = PH_RUNVAL;
                    end
                    else if (b != '0)
                    begin
                        pend_next  = b;
                        phase_next = PH_LIT;
                    end
                end

                PH_RUNVAL:
                begin
                    res_n      = RN_W'(1);
                    res[0]     = make_span(ch_reg, pos_reg, run_len, b, 1'b0,
                                           run_clip ? ST_CLIP : ST_OK);
                    pend_next  = '0;
                    phase_next = PH_CODE;
                    pos_next   = run_end;
                    if (run_end >= line_width_reg)
                    begin
                        pos_next = '0;
                        if (ch_reg == CH_W'(3))
                        begin
                            res[0].line_done = 1'b1;
                            restart          = 1'b1;
                        end
                        else
                        begin
                            ch_next = ch_reg + CH_W'(1);
                        end
                    end
                end

                PH_LIT:
                begin
                    res_n = RN_W'(1);
                    if (pos_reg < line_width_reg)
                    begin
                        res[0] = make_span(ch_reg, pos_reg, BYTE_W'(1), b, 1'b0, ST_OK);
                    end
                    else
                    begin
                        // past line end: byte consumed to keep alignment
                        res[0] = make_span(ch_reg, pos_reg, '0, b, 1'b0, ST_CLIP);
                    end
                    pos_next  = lit_end;
                    pend_next = pend_dec;
                    if (pend_dec == '0)
                    begin
                        phase_next = PH_CODE;
                        if (lit_end >= line_width_reg)
                        begin
                            pos_next = '0;
                            if (ch_reg == CH_W'(3))
                            begin
                                res[0].line_done = 1'b1;
                                restart          = 1'b1;
                            end
                            else
                            begin
                                ch_next = ch_reg + CH_W'(1);
                            end
                        end
                    end
                end

                default:
                begin
                    restart = 1'b1;
                end
            endcase
        end

        if (restart)
        begin
            phase_next = PH_HEADER;
            hcnt_next  = '0;
            ch_next    = '0;
            pos_next   = '0;
            pend_next  = '0;
        end

        // Tag the final beat of this byte
        for (int i = 0; i < MAX_RES; i++)
        begin
            res[i].last = (RN_W'(i + 1) == res_n);
        end
    end

    assign cnt_next = cnt_reg + CNT_W'(res_n) - CNT_W'(pop);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
            phase_reg      <= PH_HEADER;
            hcnt_reg       <= '0;
            hb_reg         <= '{default: '0};
            ch_reg         <= '0;
            pos_reg        <= '0;
            pend_reg       <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                line_width_reg <= cfg_data;
            end
            phase_reg  <= phase_next;
            hcnt_reg   <= hcnt_next;
            hb_reg     <= hb_next;
            ch_reg     <= ch_next;
            pos_reg    <= pos_next;
            pend_reg   <= pend_next;
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(res_n);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            cnt_reg    <= cnt_next;
        end
    end

    // Queue payload; up to MAX_RES entries written per cycle
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (RN_W'(i) < res_n)
            begin
                queue_reg[wr_ptr_reg + PTR_W'(i)] <= res[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output beat
    // ------------------------------------------------------------------
    assign span_out.valid       = (cnt_reg != '0);
    assign span_out.channel     = queue_reg[rd_ptr_reg].channel;
    assign span_out.start_x     = queue_reg[rd_ptr_reg].start_x;
    assign span_out.span_length = queue_reg[rd_ptr_reg].span_length;
    assign span_out.value       = queue_reg[rd_ptr_reg].value;
    assign span_out.line_done   = queue_reg[rd_ptr_reg].line_done;
    assign span_out.status      = queue_reg[rd_ptr_reg].status;
    assign span_out.last        = queue_reg[rd_ptr_reg].last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_room_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> cnt_reg <= CNT_W'(DEPTH))
        else $error("byte taken without room for its beats");

    a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> (ch_reg == '0 && pos_reg == '0 && pend_reg == '0))
        else $error("line header phase with stale line state");

    a_lit_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LIT || phase_reg == PH_RUNVAL) |-> pend_reg != '0)
        else $error("run or literal phase with zero count");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(phase_reg) && $stable(pos_reg) && $stable(ch_reg))
        else $error("decode state moved without a byte");

endmodule

/* tb/sv/rgbe_span_scoreboard_pkg.sv */
// ----------------------------------------------------------------------------
// rgbe_span_scoreboard_pkg
// Span predictor for the RGBE scanline decoder: mirrors the decode state,
// turns each accepted byte into the span beats it should cause, and checks
// the beats that come out against them in order.
// ----------------------------------------------------------------------------
package rgbe_span_scoreboard_pkg;
    import rgbe_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_RAW,
        PH_CODE,
        PH_RUNVAL,
        PH_LIT
    } decode_phase_e;

    localparam logic [CH_W-1:0] CH_RED = 2'd0;

    class span_scoreboard;
        logic [POS_W-1:0]  line_width;
        decode_phase_e     phase;
        int unsigned       hdr_cnt;
        logic [BYTE_W-1:0] hdr_bytes [3];
        logic [CH_W-1:0]   chan;
        int unsigned       pos;
        int unsigned       pend;
        span_t             expected_spans [$];
        span_t             step_spans [$];
        int unsigned       errors;

        function new();
            line_width = LINE_WIDTH_RESET;
            foreach (hdr_bytes[i])
                hdr_bytes[i] = '0;
            errors = 0;
            start_line();
        endfunction

        function void set_width(input logic [POS_W-1:0] w);
            line_width = w;
        endfunction

        function void start_line();
            phase   = PH_HEADER;
            hdr_cnt = 0;
            chan    = '0;
            pos     = 0;
            pend    = 0;
        endfunction

        function void push(input logic [CH_W-1:0] ch, input int unsigned x,
                           input int unsigned len, input logic [BYTE_W-1:0] val,
                           input logic done, input logic [STATUS_W-1:0] st);
            span_t s;
            s.channel     = ch;
            s.start_x     = POS_W'(x);
            s.span_length = BYTE_W'(len);
            s.value       = val;
            s.line_done   = done;
            s.status      = st;
            s.last        = 1'b0;
            step_spans.push_back(s);
        endfunction

        function void mark_done();
            span_t s;
            s = step_spans.pop_back();
            s.line_done = 1'b1;
            step_spans.push_back(s);
        endfunction

        // one raw byte into the current pixel
        function void raw_take(input logic [BYTE_W-1:0] b);
            if (pos >= line_width) begin
                push(chan, pos, 0, b, 1'b1, ST_CLIP);
                start_line();
                return;
            end
            push(chan, pos, 1, b, 1'b0, ST_OK);
            chan = chan + 1'b1;
            if (chan == 0) begin
                pos++;
                if (pos >= line_width) begin
                    mark_done();
                    start_line();
                end
            end
        endfunction

        // channel plane ends once position reaches the line width
        function void rle_end();
            if (pos < line_width)
                return;
            pos = 0;
            if (chan == 2'd3) begin
                mark_done();
                start_line();
            end
            else begin
                chan  = chan + 1'b1;
                phase = PH_CODE;
            end
        endfunction

        function void rle_run(input int unsigned n, input logic [BYTE_W-1:0] val);
            int unsigned avail;
            int unsigned len;
            avail = (line_width > pos) ? line_width - pos : 0;
            len   = (n < avail) ? n : avail;
            push(chan, pos, len, val, 1'b0, (len < n) ? ST_CLIP : ST_OK);
            pos += len;
        endfunction

        function void predict_spans(input logic [BYTE_W-1:0] b);
            span_t s;
            step_spans.delete();
            case (phase)
                PH_HEADER: begin
                    if (hdr_cnt == 0 &&
                        (line_width < MIN_RLE_WIDTH || line_width > MAX_RLE_WIDTH)) begin
                        phase = PH_RAW;
                        raw_take(b);
                    end
                    else if (hdr_cnt < 3) begin
                        hdr_bytes[hdr_cnt] = b;
                        hdr_cnt++;
                    end
                    else begin
                        hdr_cnt = 0;
                        if (hdr_bytes[0] != HDR_MARK || hdr_bytes[1] != HDR_MARK ||
                            (hdr_bytes[2] & RUN_FLAG) != 0) begin
                            // old-format line: header replayed as pixel 0
                            phase = PH_RAW;
                            for (int i = 0; i < 3 && phase == PH_RAW; i++)
                                raw_take(hdr_bytes[i]);
                            if (phase == PH_RAW)
                                raw_take(b);
                        end
                        else if ({hdr_bytes[2], b} != line_width) begin
                            push(CH_RED, 0, 0, '0, 1'b1, ST_MISMATCH);
                            start_line();
                        end
                        else begin
                            phase = PH_CODE;
                            chan  = '0;
                            pos   = 0;
                        end
                    end
                end
                PH_RAW: begin
                    raw_take(b);
                end
                PH_CODE: begin
                    if (b > RUN_FLAG) begin
                        pend  = b & COUNT_MASK;
                        phase = PH_RUNVAL;
                    end
                    else if (b != 0) begin
                        pend  = b;
                        phase = PH_LIT;
                    end
                end
                PH_RUNVAL: begin
                    phase = PH_CODE;
                    rle_run(pend, b);
                    pend = 0;
                    rle_end();
                end
                default: begin
                    if (pos < line_width) begin
                        push(chan, pos, 1, b, 1'b0, ST_OK);
                        pos++;
                    end
                    else begin
                        push(chan, pos, 0, b, 1'b0, ST_CLIP);
                    end
                    if (pend > 0)
                        pend--;
                    if (pend == 0) begin
                        phase = PH_CODE;
                        rle_end();
                    end
                end
            endcase
            if (step_spans.size() > 0) begin
                s = step_spans.pop_back();
                s.last = 1'b1;
                step_spans.push_back(s);
            end
            foreach (step_spans[i])
                expected_spans.push_back(step_spans[i]);
        endfunction

        function void field_check(input string name, input logic [15:0] want,
                                  input logic [15:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_span(input span_t got);
            span_t want;
            if (expected_spans.size() == 0) begin
                errors++;
                $display("%0t: unexpected span beat, expected none, got ch %0d x %0d len %0d val %0h",
                         $time, got.channel, got.start_x, got.span_length, got.value);
                return;
            end
            want = expected_spans.pop_front();
            field_check("channel", 16'(want.channel), 16'(got.channel));
            field_check("start_x", want.start_x, got.start_x);
            field_check("span_length", 16'(want.span_length), 16'(got.span_length));
            field_check("value", 16'(want.value), 16'(got.value));
            field_check("line_done", 16'(want.line_done), 16'(got.line_done));
            field_check("status", 16'(want.status), 16'(got.status));
            field_check("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

endpackage

/* tb/sv/rgbe_scanline_rle_decoder_test.sv */
// ----------------------------------------------------------------------------
// rgbe_scanline_rle_decoder_test
// Self-checking bench for the RGBE scanline decoder. Drives byte streams made
// of well-formed run-length lines, old-format raw lines, bad headers and
// noise, predicts every span beat, and checks each beat in order while both
// handshakes idle and stall at random, under several line widths.
// ----------------------------------------------------------------------------
module rgbe_scanline_rle_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbe_pkg::*;
    import rgbe_span_scoreboard_pkg::*;

    // Generous cycle budget; a correct run needs a small fraction of it.
    localparam int unsigned CYCLE_LIMIT = 200000;
    // Minimum bytes per random phase.
    localparam int unsigned PHASE_BYTES = 30;

    typedef logic [BYTE_W-1:0] byte_seq_t [$];

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [POS_W-1:0] cfg_data;

    rgbe_byte_if byte_ch ();
    rgbe_span_if span_ch ();

    span_scoreboard sb;

    int unsigned send_idle_pct;   // chance per cycle that the byte source idles
    int unsigned recv_stall_pct;  // chance per cycle that the span sink stalls
    logic        span_hold;       // long sink hold-off, forces input backpressure
    int unsigned bytes_sent;
    int unsigned cycles;

    rgbe_scanline_rle_decoder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .byte_in  (byte_ch),
        .span_out (span_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Span sink: ready toggles at the falling edge, beats are checked at the
    // rising edge against the oldest predicted span.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        span_ch.ready <= !span_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin : span_monitor
        span_t got;
        if (rst_n === 1'b1 && span_ch.valid === 1'b1 && span_ch.ready === 1'b1) begin
            got.channel     = span_ch.channel;
            got.start_x     = span_ch.start_x;
            got.span_length = span_ch.span_length;
            got.value       = span_ch.value;
            got.line_done   = span_ch.line_done;
            got.status      = span_ch.status;
            got.last        = span_ch.last;
            sb.check_span(got);
        end
    end

    // Watchdog: a hung handshake or missing beats end here.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Byte source. Tasks are entered and left at a falling edge; valid is only
    // assigned once per edge, so back-to-back beats keep it high.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!(byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1));
        sb.predict_spans(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_seq(input byte_seq_t seq);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // All predicted beats out, then an idle wait for a byte that gives no beat.
    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        while (sb.expected_spans.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // line_width takes effect at the write edge, mid-line included
    task automatic write_width(input logic [POS_W-1:0] w);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= w;
        @(posedge clk);
        sb.set_width(w);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic hold_output(input int unsigned n);
        span_hold <= 1'b1;
        repeat (n) @(posedge clk);
        span_hold <= 1'b0;
    endtask

    // Mostly short RLE-capable widths so lines stay cheap; sometimes raw-only.
    function automatic logic [POS_W-1:0] pick_width();
        if ($urandom_range(4) == 0)
            return POS_W'($urandom_range(7, 1));
        return POS_W'($urandom_range(20, 8));
    endfunction

    // ------------------------------------------------------------------------
    // Line generators
    // ------------------------------------------------------------------------

    // Feed filler until the decoder is back at a line start. A run code closes
    // any open channel plane since random widths stay far below 127.
    task automatic finish_line();
        while (!(sb.phase == PH_HEADER && sb.hdr_cnt == 0)) begin
            if (sb.phase == PH_CODE)
                send_byte(8'hFF);
            else
                send_byte(BYTE_W'($urandom));
        end
    endtask

    // Old-format line (header replayed as pixel 0), or plain raw pixels
    // when the width is outside the run-length range.
    task automatic send_raw_line();
        int unsigned w;
        logic [BYTE_W-1:0] first;
        w     = sb.line_width;
        first = BYTE_W'($urandom);
        if (first == HDR_MARK)
            first = first ^ 8'h01;
        send_byte(first);
        repeat (4 * w - 1) send_byte(BYTE_W'($urandom));
    endtask

    // Well-formed run-length line with random runs and literals; now and then
    // an empty literal or a span that overshoots the line end.
    task automatic send_rle_line();
        logic [POS_W-1:0] lw;
        int unsigned col;
        int unsigned rem;
        int unsigned n;
        lw = sb.line_width;
        if (lw < MIN_RLE_WIDTH) begin
            send_raw_line();
            return;
        end
        send_seq('{HDR_MARK, HDR_MARK, lw[15:8], lw[7:0]});
        repeat (4) begin
            col = 0;
            while (col < lw) begin
                rem = lw - col;
                if ($urandom_range(9) == 0)
                    send_byte(8'h00);
                n = $urandom_range(rem, 1);
                if ($urandom_range(9) == 0)
                    n = rem + $urandom_range(4, 1);
                if ($urandom_range(1) == 1) begin
                    send_byte(RUN_FLAG | BYTE_W'(n));
                    send_byte(BYTE_W'($urandom));
                end
                else begin
                    send_byte(BYTE_W'(n));
                    repeat (n) send_byte(BYTE_W'($urandom));
                end
                col += n;
            end
        end
    endtask

    // Run-length header whose width disagrees with line_width.
    task automatic send_bad_header();
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
        hi = ($urandom_range(1) == 1) ? BYTE_W'($urandom_range(127)) : 8'h00;
        lo = BYTE_W'($urandom);
        if ({hi, lo} == sb.line_width)
            lo = lo ^ 8'h01;
        send_seq('{HDR_MARK, HDR_MARK, hi, lo});
    endtask

    // Noise, half of it posing as a header start.
    task automatic send_noise();
        if ($urandom_range(1) == 1)
            send_seq('{HDR_MARK, HDR_MARK});
        repeat ($urandom_range(8, 1)) send_byte(BYTE_W'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Directed stream: width extremes, every line type, clipping cases,
    // empty literal, mid-line width changes.
    // ------------------------------------------------------------------------
    task automatic run_directed();
        // raw width at the top of the range, then shrink to 1 mid-pixel
        write_width(16'hFFFF);
        send_seq('{8'h00, 8'hFF});
        write_width(16'd1);
        send_seq('{8'h5A, 8'hA5});
        // zero width: every raw byte lands past the end
        write_width(16'd0);
        send_seq('{8'h7F});
        // RLE line at the minimum width: empty literal, clipped run,
        // literal running past the end, full runs to close the line
        write_width(MIN_RLE_WIDTH);
        send_seq('{HDR_MARK, HDR_MARK, 8'h00, 8'h08,
                   8'h00, 8'hFF, 8'hAA,
                   8'h86, 8'h44, 8'h03, 8'h11, 8'h22, 8'h33,
                   8'h88, 8'h00,
                   8'h88, 8'hFF});
        // header width mismatch
        send_seq('{HDR_MARK, HDR_MARK, 8'h00, 8'h09});
        // old-format header replay, then a raw byte past a shrunken width
        send_seq('{8'h01, 8'h02, 8'h03, 8'h04});
        write_width(16'd1);
        send_seq('{8'h80});
        // widest RLE line; the next phase shrinks the width mid-channel
        write_width(MAX_RLE_WIDTH);
        send_seq('{HDR_MARK, HDR_MARK, 8'h7F, 8'hFF, 8'hFF, 8'h07});
    endtask

    // ------------------------------------------------------------------------
    // One random phase under the given idle/stall rates. With squeeze set the
    // sink holds off while raw lines keep coming, so the result queue fills
    // and the byte channel backs up.
    // ------------------------------------------------------------------------
    task automatic run_phase(input int unsigned snd_pct, input int unsigned rcv_pct,
                             input bit squeeze);
        int unsigned goal;
        int unsigned pick;
        wait_idle();
        send_idle_pct  = snd_pct;
        recv_stall_pct = rcv_pct;
        write_width(pick_width());
        goal = bytes_sent + PHASE_BYTES;
        if (squeeze) begin
            fork
                hold_output(80);
                begin
                    repeat (3) begin
                        finish_line();
                        send_raw_line();
                    end
                end
            join
        end
        while (bytes_sent < goal) begin
            if ($urandom_range(3) == 0)
                write_width(pick_width());
            finish_line();
            pick = $urandom_range(99);
            if (pick < 65)
                send_rle_line();
            else if (pick < 78)
                send_raw_line();
            else if (pick < 88)
                send_bad_header();
            else
                send_noise();
        end
    endtask

    initial begin
        sb                = new();
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_data          = '0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        span_ch.ready     = 1'b0;
        span_hold         = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        bytes_sent        = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_phase(0, 0, 1'b1);
        run_phase(72, 0, 1'b0);
        run_phase(0, 72, 1'b0);
        run_phase(8, 8, 1'b0);

        // drain, then leave room for any stray beat to show up
        byte_ch.valid <= 1'b0;
        while (sb.expected_spans.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.errors == 0 && sb.expected_spans.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/core/rgbe_pkg.sv
rtl/core/rgbe_byte_if.sv
rtl/core/rgbe_span_if.sv
rtl/core/rgbe_scanline_rle_decoder.sv
tb/sv/rgbe_span_scoreboard_pkg.sv
tb/sv/rgbe_scanline_rle_decoder_test.sv
